FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the ready queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define PRQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that must hold whenever the given valid is high.
`define PRQ_ASSERT_WHEN(lbl, clk, rstn, vld, cond, msg) \
  `PRQ_ASSERT(lbl, clk, rstn, (vld) |-> (cond), msg)

`endif

FILE: hdl/prq_pkg.sv
// Shared types and constants of the priority ready queue.
// No dependencies; used by the cells, the top level and the checker.
package prq_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed field widths of the ports
  localparam int CMD_W    = 2;
  localparam int INPRIO_W = 8;
  localparam int SEL_W    = 5;
  localparam int STAT_W   = 2;
  localparam int OSLOT_W  = 5;

  typedef enum logic [1:0] {
    CMD_ACT  = 2'd0,
    CMD_TERM = 2'd1,
    CMD_SUSP = 2'd2,
    CMD_RES  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NORES  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TS_FREE  = 2'd0,
    TS_READY = 2'd1,
    TS_SUSP  = 2'd2
  } tstat_t;

  typedef enum logic [1:0] {
    ROP_NONE   = 2'd0,
    ROP_INSERT = 2'd1,
    ROP_REMOVE = 2'd2
  } rop_t;

  typedef enum logic [1:0] {
    FOP_NONE = 2'd0,
    FOP_PUSH = 2'd1,
    FOP_POP  = 2'd2
  } fop_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Command broadcast to every ready cell
  typedef struct packed {
    rop_t op;
    logic ahead;
  } rcmd_t;

endpackage

FILE: hdl/prq_ready_cell.sv
// One cell of the sorted ready chain: holds a slot and its priority.
// Depends on prq_pkg.
module prq_ready_cell #(
  parameter int POS       = 0,
  parameter int SLOT_W    = 5,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prq_pkg::rcmd_t       cmd,
  input  logic [PRIO_BITS-1:0] key,
  input  logic [SLOT_W-1:0]    new_slot,
  input  logic [SLOT_W-1:0]    rm_idx,
  input  logic                 left_valid,
  input  logic [SLOT_W-1:0]    left_slot,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic                 left_before,
  input  logic                 right_valid,
  input  logic [SLOT_W-1:0]    right_slot,
  input  logic [PRIO_BITS-1:0] right_prio,
  output logic                 valid,
  output logic [SLOT_W-1:0]    slot,
  output logic [PRIO_BITS-1:0] prio,
  output logic                 precedes
);
  import prq_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  // This entry stays ahead of the new one
  assign precedes = valid_r && ((prio_r > key) || (!cmd.ahead && (prio_r == key)));

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    prio_nxt  = prio_r;
    case (cmd.op)
      ROP_INSERT: begin
        if (!precedes) begin
          if (left_before) begin
            valid_nxt = 1'b1;
            slot_nxt  = new_slot;
            prio_nxt  = key;
          end else begin
            valid_nxt = left_valid;
            slot_nxt  = left_slot;
            prio_nxt  = left_prio;
          end
        end
      end
      ROP_REMOVE: begin
        if (SLOT_W'(POS) >= rm_idx) begin
          valid_nxt = right_valid;
          slot_nxt  = right_slot;
          prio_nxt  = right_prio;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign slot  = slot_r;
  assign prio  = prio_r;

endmodule

FILE: hdl/prq_free_cell.sv
// One cell of the free-slot stack; position zero is the top.
// Depends on prq_pkg.
module prq_free_cell #(
  parameter int POS    = 0,
  parameter int SLOT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prq_pkg::fop_t     op,
  input  logic [SLOT_W-1:0] push_slot,
  input  logic              left_valid,
  input  logic [SLOT_W-1:0] left_slot,
  input  logic              right_valid,
  input  logic [SLOT_W-1:0] right_slot,
  output logic              valid,
  output logic [SLOT_W-1:0] slot
);
  import prq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    case (op)
      FOP_PUSH: begin
        if (POS == 0) begin
          valid_nxt = 1'b1;
          slot_nxt  = push_slot;
        end else begin
          valid_nxt = left_valid;
          slot_nxt  = left_slot;
        end
      end
      FOP_POP: begin
        valid_nxt = right_valid;
        slot_nxt  = right_slot;
      end
      default: ;
    endcase
  end

  // Reset chains every slot in ascending order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b1;
      slot_r  <= SLOT_W'(POS);
    end else begin
      valid_r <= valid_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign valid = valid_r;
  assign slot  = slot_r;

endmodule

FILE: hdl/priority_ready_queue.sv
// Top level of the priority ready queue: ready chain, free stack, control.
// Depends on prq_pkg, prq_ready_cell and prq_free_cell.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------
//  in_     | in        | in_valid / in_ready  | cmd, prio, insert_at_head, task_sel
//  out_    | out       | out_valid / out_ready| status, slot, running_valid,
//          |           |                      | running_task, switched
//
// The accept edge of a command registers the checks, the chain index of the
// selected slot and the priority table read; the commit edge then shifts the
// cell chains and loads the result word. A new word is taken only after the
// previous command has committed, as the priority table read is registered
// ahead of the ready chain update.
// On reset the cell chains load their initial contents at once.
// A result word that is not taken holds the command back from its commit;
// the next input word is taken as soon as the result register is loaded.
module priority_ready_queue #(
  parameter int NUM_SLOTS = prq_pkg::NUM_SLOTS_DEF,
  parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [prq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [prq_pkg::INPRIO_W-1:0] in_prio,
  input  logic                         in_insert_at_head,
  input  logic [prq_pkg::SEL_W-1:0]    in_task_sel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prq_pkg::STAT_W-1:0]   out_status,
  output logic [prq_pkg::OSLOT_W-1:0]  out_slot,
  output logic                         out_running_valid,
  output logic [prq_pkg::OSLOT_W-1:0]  out_running_task,
  output logic                         out_switched
);
  import prq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  // Cell chain taps
  logic                 r_valid  [NUM_SLOTS];
  logic [SLOT_W-1:0]    r_slot   [NUM_SLOTS];
  logic [PRIO_BITS-1:0] r_prio   [NUM_SLOTS];
  logic                 r_before [NUM_SLOTS];
  logic                 f_valid  [NUM_SLOTS];
  logic [SLOT_W-1:0]    f_slot   [NUM_SLOTS];

  // Per-slot status flops and the priority table
  tstat_t               tstat_r [NUM_SLOTS];
  logic [PRIO_BITS-1:0] prio_mem [NUM_SLOTS];
  logic [PRIO_BITS-1:0] prio_rd_r;

  state_t state_r, state_nxt;
  logic   accept, commit;

  // Command registered at the accept edge
  cmd_t                 cmd_r;
  status_t              status_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    idx_r;
  logic                 ahead_r;
  logic [PRIO_BITS-1:0] key_r;

  // Accept-time decode
  cmd_t                 in_cmd_e;
  logic [PRIO_BITS-1:0] prio_k;
  logic [SLOT_W-1:0]    sel_idx;
  logic                 in_range;
  tstat_t               sel_stat;
  logic [SLOT_W-1:0]    match_idx;
  status_t              dec_status;
  logic [SLOT_W-1:0]    dec_slot;
  logic [SLOT_W-1:0]    dec_idx;

  // Commit-time controls
  rcmd_t                rcmd;
  fop_t                 fop;
  logic [PRIO_BITS-1:0] key;
  logic                 head_valid_nxt;
  logic [SLOT_W-1:0]    head_slot_nxt;
  logic                 ok;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [OSLOT_W-1:0]   out_slot_r;
  logic                 out_run_valid_r;
  logic [OSLOT_W-1:0]   out_run_task_r;
  logic                 out_switched_r;

  assign in_cmd_e = cmd_t'(in_cmd);
  assign prio_k   = PRIO_BITS'(in_prio);   // drop or zero-fill to the table width
  assign sel_idx  = SLOT_W'(in_task_sel);
  assign in_range = int'(in_task_sel) < NUM_SLOTS;
  assign sel_stat = tstat_r[sel_idx];

  // Position of the selected slot in the ready chain (at most one match)
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (r_valid[i] && (r_slot[i] == sel_idx)) begin
        match_idx = match_idx | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    dec_status = ST_OK;
    dec_slot   = '0;
    dec_idx    = '0;
    case (in_cmd_e)
      CMD_ACT: begin
        if (f_valid[0]) dec_slot = f_slot[0];
        else dec_status = ST_NOFREE;
      end
      CMD_TERM: begin
        if (r_valid[0]) dec_slot = r_slot[0];
        else dec_status = ST_EMPTY;
      end
      CMD_SUSP: begin
        if (in_range && (sel_stat == TS_READY)) begin
          dec_slot = sel_idx;
          dec_idx  = match_idx;
        end else begin
          dec_status = ST_NORES;
        end
      end
      default: begin
        if (in_range && (sel_stat == TS_SUSP)) dec_slot = sel_idx;
        else dec_status = ST_NORES;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: commit = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the decoded command for the chain update
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd_e;
      status_r <= dec_status;
      slot_r   <= dec_slot;
      idx_r    <= dec_idx;
      ahead_r  <= (in_cmd_e == CMD_ACT) && in_insert_at_head;
      key_r    <= prio_k;
    end
  end

  // Priority table: write the new task's priority, read the resumed one's
  always_ff @(posedge clk) begin
    if (accept) begin
      if ((in_cmd_e == CMD_ACT) && f_valid[0]) prio_mem[f_slot[0]] <= prio_k;
      prio_rd_r <= prio_mem[sel_idx];
    end
  end

  assign ok  = commit && (status_r == ST_OK);
  assign key = (cmd_r == CMD_RES) ? prio_rd_r : key_r;

  always_comb begin
    rcmd.op    = ROP_NONE;
    rcmd.ahead = ahead_r;
    fop        = FOP_NONE;
    if (ok) begin
      case (cmd_r)
        CMD_ACT: begin
          rcmd.op = ROP_INSERT;
          fop     = FOP_POP;
        end
        CMD_TERM: begin
          rcmd.op = ROP_REMOVE;
          fop     = FOP_PUSH;
        end
        CMD_SUSP: rcmd.op = ROP_REMOVE;
        default:  rcmd.op = ROP_INSERT;
      endcase
    end
  end

  // Head of the ready chain after this command
  always_comb begin
    head_valid_nxt = r_valid[0];
    head_slot_nxt  = r_slot[0];
    case (rcmd.op)
      ROP_INSERT: begin
        if (!r_before[0]) begin
          head_valid_nxt = 1'b1;
          head_slot_nxt  = slot_r;
        end
      end
      ROP_REMOVE: begin
        if (idx_r == '0) begin
          head_valid_nxt = r_valid[1];
          head_slot_nxt  = r_slot[1];
        end
      end
      default: ;
    endcase
  end

  // Slot status flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) tstat_r[i] <= TS_FREE;
    end else if (ok) begin
      case (cmd_r)
        CMD_TERM: tstat_r[slot_r] <= TS_FREE;
        CMD_SUSP: tstat_r[slot_r] <= TS_SUSP;
        default:  tstat_r[slot_r] <= TS_READY;
      endcase
    end
  end

  // Cell chains
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic                 lv, lb, rv, flv, frv;
    logic [SLOT_W-1:0]    ls, rs, fls, frs;
    logic [PRIO_BITS-1:0] lp, rp;

    if (g == 0) begin : g_first
      assign lv  = 1'b0;
      assign ls  = '0;
      assign lp  = '0;
      assign lb  = 1'b1;
      assign flv = 1'b0;
      assign fls = '0;
    end else begin : g_mid
      assign lv  = r_valid[g-1];
      assign ls  = r_slot[g-1];
      assign lp  = r_prio[g-1];
      assign lb  = r_before[g-1];
      assign flv = f_valid[g-1];
      assign fls = f_slot[g-1];
    end

    if (g == NUM_SLOTS - 1) begin : g_last
      assign rv  = 1'b0;
      assign rs  = '0;
      assign rp  = '0;
      assign frv = 1'b0;
      assign frs = '0;
    end else begin : g_body
      assign rv  = r_valid[g+1];
      assign rs  = r_slot[g+1];
      assign rp  = r_prio[g+1];
      assign frv = f_valid[g+1];
      assign frs = f_slot[g+1];
    end

    prq_ready_cell #(
      .POS(g), .SLOT_W(SLOT_W), .PRIO_BITS(PRIO_BITS)
    ) u_rcell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (rcmd),
      .key        (key),
      .new_slot   (slot_r),
      .rm_idx     (idx_r),
      .left_valid (lv),
      .left_slot  (ls),
      .left_prio  (lp),
      .left_before(lb),
      .right_valid(rv),
      .right_slot (rs),
      .right_prio (rp),
      .valid      (r_valid[g]),
      .slot       (r_slot[g]),
      .prio       (r_prio[g]),
      .precedes   (r_before[g])
    );

    prq_free_cell #(
      .POS(g), .SLOT_W(SLOT_W)
    ) u_fcell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (fop),
      .push_slot  (slot_r),
      .left_valid (flv),
      .left_slot  (fls),
      .right_valid(frv),
      .right_slot (frs),
      .valid      (f_valid[g]),
      .slot       (f_slot[g])
    );
  end

  // Result register: load on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r    <= status_r;
      out_slot_r      <= (status_r == ST_OK) ? OSLOT_W'(slot_r) : '0;
      out_run_valid_r <= head_valid_nxt;
      out_run_task_r  <= head_valid_nxt ? OSLOT_W'(head_slot_nxt) : '0;
      out_switched_r  <= (head_valid_nxt != r_valid[0]) ||
                         (head_valid_nxt && (head_slot_nxt != r_slot[0]));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_running_valid = out_run_valid_r;
  assign out_running_task  = out_run_task_r;
  assign out_switched      = out_switched_r;

endmodule

FILE: hdl/prq_checker.sv
// Port-level checks of the priority ready queue, bound to its top level.
// Depends on prq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [prq_pkg::STAT_W-1:0]   out_status,
  input logic [prq_pkg::OSLOT_W-1:0]  out_slot,
  input logic                         out_running_valid,
  input logic [prq_pkg::OSLOT_W-1:0]  out_running_task,
  input logic                         out_switched
);
  import prq_pkg::*;

  // A stalled result word holds
  `PRQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot) && $stable(out_running_valid) && $stable(out_running_task) && $stable(out_switched), "result word changed while stalled")

  // Failed commands report slot zero
  `PRQ_ASSERT_WHEN(a_fail_slot, clk, rst_n, out_valid && (out_status != ST_OK), out_slot == '0, "failed command reports a slot")

  // No running task reads as task zero
  `PRQ_ASSERT_WHEN(a_idle_task, clk, rst_n, out_valid && !out_running_valid, out_running_task == '0, "idle scheduler reports a task")

  // One command at a time: the cycle after an accept takes no word
  `PRQ_ASSERT(a_one_cmd, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken in the second cycle")

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_slot         (out_slot),
  .out_running_valid(out_running_valid),
  .out_running_task (out_running_task),
  .out_switched     (out_switched)
);
